// ===== rtl/scrpa_pkg.sv =====
// ----------------------------------------------------------------------------
// scrpa_pkg: shared types and constants for the size-class ring pool allocator
// Holds slot store geometry, outcome codes and the front-to-back command type.
// ----------------------------------------------------------------------------
package scrpa_pkg;

    localparam int SLOT_COUNT  = 524288;
    localparam int N_CLASSES   = 150;
    localparam int SLOT_W      = $clog2(SLOT_COUNT);
    localparam int CLASS_W     = $clog2(N_CLASSES);
    localparam int Q_DEPTH     = 2;
    localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(SLOT_COUNT - 1);
    localparam logic [CLASS_W-1:0] CLASS_MAX = CLASS_W'(N_CLASSES - 1);

    localparam logic [31:0] ARENA_GAP = 32'd8;

    // Outcome codes
    localparam logic [2:0] OUT_POPPED   = 3'd0;
    localparam logic [2:0] OUT_ARENA    = 3'd1;
    localparam logic [2:0] OUT_ALLOC_GH = 3'd2;
    localparam logic [2:0] OUT_STORED   = 3'd3;
    localparam logic [2:0] OUT_FREE_GH  = 3'd4;
    localparam logic [2:0] OUT_DROPPED  = 3'd5;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Configuration register indexes
    localparam logic CFG_ARENA_BASE = 1'b0;
    localparam logic CFG_DISABLE    = 1'b1;

    // Classified command handed from front to back
    typedef struct packed {
        logic               small_op;  // needs class work
        logic               is_rel;
        logic [CLASS_W-1:0] cls;
        logic [31:0]        size;
        logic [31:0]        handle;
        logic [2:0]         outcome;   // final code for items that skip class work
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_CLS,      // read head/tail of class
        S_POP_RD,      // slot read issued
        S_POP_WAIT,
        S_PUSH_NXT,    // read next class indices
        S_PUSH_CHK,
        S_PUSH_SWAP,   // slot read for move
        S_PUSH_SWAP2,
        S_PUSH_END,
        S_OUT
    } t_state;

    function automatic logic [SLOT_W-1:0] idx_up(input logic [SLOT_W-1:0] x);
        return (x == SLOT_MAX) ? '0 : x + 1'b1;
    endfunction

    function automatic logic [CLASS_W-1:0] cls_up(input logic [CLASS_W-1:0] c);
        return (c == CLASS_MAX) ? '0 : c + 1'b1;
    endfunction

endpackage

// ===== rtl/scrpa_front.sv =====
// ----------------------------------------------------------------------------
// scrpa_front: input stage and command queue
// Accepts items, classifies them by opcode and size, and holds them in a
// short queue for the back end.
// ----------------------------------------------------------------------------
module scrpa_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_opcode,
    input  logic [31:0]       i_request_size,
    input  logic [31:0]       i_block_handle,
    input  logic              i_disabled,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready,
    output scrpa_pkg::t_cmd   o_cmd
);
    import scrpa_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);

    t_cmd             r_q [Q_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [PTR_W:0]   r_cnt;
    t_cmd             n_cmd;
    logic             push, pop, is_small;

    // Classify
    always_comb begin
        is_small      = i_request_size < 32'(N_CLASSES);
        n_cmd.is_rel  = i_opcode == OP_RELEASE;
        n_cmd.cls     = i_request_size[CLASS_W-1:0];
        n_cmd.size    = i_request_size;
        n_cmd.handle  = i_block_handle;
        n_cmd.small_op = is_small && !(n_cmd.is_rel && i_disabled);
        if (!is_small)
            n_cmd.outcome = n_cmd.is_rel ? OUT_FREE_GH : OUT_ALLOC_GH;
        else
            n_cmd.outcome = n_cmd.is_rel ? OUT_DROPPED : OUT_POPPED;
    end

    assign o_ready     = r_cnt != (PTR_W+1)'(Q_DEPTH);
    assign o_cmd_valid = r_cnt != '0;
    assign o_cmd       = r_q[r_rd];
    assign push        = i_valid && o_ready;
    assign pop         = o_cmd_valid && i_cmd_ready;

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push)
            r_q[r_wr] <= n_cmd;
    end

    // Queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= r_wr + 1'b1;
            if (pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
        end
    end

endmodule

// ===== rtl/scrpa_back.sv =====
// ----------------------------------------------------------------------------
// scrpa_back: class engine
// Sequencer that pops and pushes classes in the shared slot store, walks the
// collision chain one class per pass, and keeps the arena and counters.
// ----------------------------------------------------------------------------
module scrpa_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    output logic              o_cmd_ready,
    input  scrpa_pkg::t_cmd   i_cmd,
    input  logic [31:0]       i_arena_base,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [31:0]       o_result_block,
    output logic [2:0]        o_outcome,
    output logic [31:0]       o_live_blocks,
    output logic [31:0]       o_peak_blocks
);
    import scrpa_pkg::*;

    // Memories: slot store, class heads and tails
    logic [31:0]       r_slot [SLOT_COUNT];
    logic [SLOT_W-1:0] r_head [N_CLASSES];
    logic [SLOT_W-1:0] r_tail [N_CLASSES];
    logic [N_CLASSES-1:0] r_cv;   // class indices written since reset

    t_state            r_st, n_st;
    t_cmd              r_cmd;
    logic [CLASS_W-1:0] r_cur;
    logic [SLOT_W-1:0]  r_h, r_t, r_ptail;
    logic [31:0]        r_carry, r_sdata;
    logic [31:0]        r_live, r_peak, r_off;
    logic [31:0]        r_res;
    logic [2:0]         r_code;

    // Memory access controls (combinational)
    logic [CLASS_W-1:0] ix_rd;
    logic [SLOT_W-1:0]  h_rd, t_rd;
    logic               hw_en, tw_en, sw_en;
    logic [CLASS_W-1:0] hw_a, tw_a;
    logic [SLOT_W-1:0]  hw_d, tw_d, sw_a, s_ra;
    logic [31:0]        sw_d;

    // Index and slot memory reads (registered data) and writes
    always_ff @(posedge i_clk) begin
        h_rd   <= r_head[ix_rd];
        t_rd   <= r_tail[ix_rd];
        r_sdata <= r_slot[s_ra];
        if (hw_en) r_head[hw_a] <= hw_d;
        if (tw_en) r_tail[tw_a] <= tw_d;
        if (sw_en) r_slot[sw_a] <= sw_d;
    end

    // Unwritten classes read as empty: head zero, tail at the top slot
    logic r_cvr;
    logic [SLOT_W-1:0] h_q, t_q;
    assign h_q = r_cvr ? h_rd : '0;
    assign t_q = r_cvr ? t_rd : SLOT_MAX;

    assign o_cmd_ready    = r_st == S_IDLE;
    assign o_valid        = r_st == S_OUT;
    assign o_result_block = r_res;
    assign o_outcome      = r_code;
    assign o_live_blocks  = r_live;
    assign o_peak_blocks  = r_peak;

    // Next state and memory controls; head and tail are always written together
    always_comb begin
        n_st  = r_st;
        ix_rd = r_cur;
        s_ra  = r_t;
        hw_en = 1'b0; tw_en = 1'b0; sw_en = 1'b0;
        hw_a  = r_cur; tw_a = r_cur;
        hw_d  = idx_up(r_h); tw_d = idx_up(r_t);
        sw_a  = r_h; sw_d = r_carry;
        case (r_st)
            S_IDLE: begin
                ix_rd = i_cmd.cls;
                if (i_cmd_valid)
                    n_st = i_cmd.small_op ? S_RD_CLS : S_OUT;
            end
            S_RD_CLS: begin
                if (!r_cmd.is_rel)
                    n_st = (h_q == idx_up(t_q)) ? S_OUT : S_POP_RD;
                else begin
                    hw_en = 1'b1; hw_d = h_q;
                    tw_en = 1'b1; tw_d = idx_up(t_q);
                    n_st  = S_PUSH_NXT;
                end
                s_ra = t_q;
            end
            S_POP_RD: begin
                hw_en = 1'b1; hw_d = r_h;
                tw_en = 1'b1;
                tw_d  = (r_t == '0) ? SLOT_MAX : r_t - 1'b1;
                n_st  = S_POP_WAIT;
            end
            S_POP_WAIT: n_st = S_OUT;
            S_PUSH_NXT: n_st = S_PUSH_CHK;
            S_PUSH_CHK: begin
                if (r_cur == r_cmd.cls || r_ptail != h_q)
                    n_st = S_PUSH_END;
                else if (h_q != idx_up(t_q)) begin
                    s_ra = h_q;
                    n_st = S_PUSH_SWAP;
                end else begin
                    hw_en = 1'b1; hw_d = idx_up(h_q);
                    tw_en = 1'b1; tw_d = idx_up(t_q);
                    n_st  = S_PUSH_NXT;
                end
            end
            S_PUSH_SWAP: begin
                s_ra  = r_h;
                sw_en = 1'b1; sw_a = r_h; sw_d = r_carry;
                hw_en = 1'b1; tw_en = 1'b1;
                n_st  = S_PUSH_NXT;
            end
            S_PUSH_END: begin
                sw_en = 1'b1; sw_a = r_ptail; sw_d = r_carry;
                n_st  = S_OUT;
            end
            S_OUT: if (i_ready) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
        if (r_st == S_PUSH_CHK || r_st == S_PUSH_SWAP || r_st == S_PUSH_NXT)
            ix_rd = r_cur;
    end

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_cv   <= '0;
            r_live <= '0;
            r_peak <= '0;
            r_off  <= '0;
            r_cvr  <= 1'b0;
        end else begin
            r_st  <= n_st;
            r_cvr <= r_cv[ix_rd];
            if (hw_en) r_cv[hw_a] <= 1'b1;
            case (r_st)
                S_RD_CLS: begin
                    if (!r_cmd.is_rel && h_q == idx_up(t_q))
                        r_off <= r_off + r_cmd.size;
                    else if (!r_cmd.is_rel)
                        r_live <= r_live - 1'b1;
                end
                S_PUSH_END: begin
                    r_live <= r_live + 1'b1;
                    if ($signed(r_live + 1'b1) > $signed(r_peak))
                        r_peak <= r_live + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_st)
            S_IDLE: begin
                r_cmd <= i_cmd;
                r_cur <= i_cmd.cls;
                r_carry <= i_cmd.handle;
                r_res <= '0;
                r_code <= i_cmd.outcome;
            end
            S_RD_CLS: begin
                r_h <= h_q;
                r_t <= t_q;
                if (!r_cmd.is_rel && h_q == idx_up(t_q)) begin
                    r_res  <= i_arena_base + ARENA_GAP + r_off;
                    r_code <= OUT_ARENA;
                end else if (r_cmd.is_rel) begin
                    r_ptail <= idx_up(t_q);
                    r_cur   <= cls_up(r_cur);
                    r_code  <= OUT_STORED;
                end
            end
            S_POP_WAIT: begin
                r_res  <= r_sdata;
                r_code <= OUT_POPPED;
            end
            S_PUSH_CHK: begin
                r_h <= h_q;
                r_t <= t_q;
                if (!(r_cur == r_cmd.cls || r_ptail != h_q) && h_q == idx_up(t_q)) begin
                    r_ptail <= idx_up(t_q);
                    r_cur   <= cls_up(r_cur);
                end
            end
            S_PUSH_SWAP: begin
                r_carry <= r_sdata;
                r_ptail <= idx_up(r_t);
                r_cur   <= cls_up(r_cur);
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/size_class_ring_pool_allocator_top.sv =====
// ----------------------------------------------------------------------------
// size_class_ring_pool_allocator_top: size-class ring pool allocator
// Front queue plus class engine over a shared circular slot store.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) carries opcode, request size and block
//   handle; output channel (o_valid/i_ready) returns one item per input.
//   Configuration is written through i_cfg_we/i_cfg_index/i_cfg_data; the
//   user must do so only while the block is idle, which it does not enforce.
//   A release also steps through each following class that its push runs
//   into and shifts the blocks of the occupied ones. The class engine
//   handles one item at a time and takes the next once the result is
//   accepted; its slot store, with one read and one write port, and the
//   chain walk set the rate. A two-entry queue lets the front take items
//   while it works.
//   Reset empties every class and zeroes the counters and arena offset;
//   slot contents are left as they are. A stalled receiver holds the
//   result in the output register and the engine waits.
// ----------------------------------------------------------------------------
module size_class_ring_pool_allocator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_opcode,
    input  logic [31:0] i_request_size,
    input  logic [31:0] i_block_handle,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_result_block,
    output logic [2:0]  o_outcome,
    output logic [31:0] o_live_blocks,
    output logic [31:0] o_peak_blocks,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import scrpa_pkg::*;

    logic [31:0] r_arena_base;
    logic        r_disabled;
    logic        cmd_valid, cmd_ready;
    t_cmd        cmd;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arena_base <= '0;
            r_disabled   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ARENA_BASE: r_arena_base <= i_cfg_data;
                CFG_DISABLE:    r_disabled   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    scrpa_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_opcode, .i_request_size,
        .i_block_handle, .i_disabled(r_disabled), .o_cmd_valid(cmd_valid),
        .i_cmd_ready(cmd_ready), .o_cmd(cmd)
    );

    scrpa_back u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(cmd_valid), .o_cmd_ready(cmd_ready),
        .i_cmd(cmd), .i_arena_base(r_arena_base), .o_valid, .i_ready,
        .o_result_block, .o_outcome, .o_live_blocks, .o_peak_blocks
    );

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result_block))
        else $error("result changed while stalled");
    a_zero_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_outcome != OUT_POPPED && o_outcome != OUT_ARENA
        |-> o_result_block == '0)
        else $error("non-allocation result not zero");
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_outcome <= OUT_DROPPED)
        else $error("bad outcome code");
`endif

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the size-class ring pool allocator
// The bench feeds directed and random allocate and release items. They cover
// the arena, popping from and pushing into a class, chains of class moves,
// the general heap and dropped releases. The register writes cover the
// extreme base addresses and both release modes. Every result item is
// checked against an in-bench model of the class store.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import scrpa_pkg::*;

    typedef struct {
        logic        op;
        logic [31:0] size;
        logic [31:0] handle;
    } t_req;

    typedef struct {
        logic [31:0] blk;
        logic [2:0]  outcome;
        logic [31:0] live;
        logic [31:0] peak;
    } t_res;

    localparam int N_PHASES   = 6;
    localparam int PHASE_ITEMS = 190;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_opcode = 1'b0;
    logic [31:0] i_request_size = '0;
    logic [31:0] i_block_handle = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_result_block;
    logic [2:0]  o_outcome;
    logic [31:0] o_live_blocks;
    logic [31:0] o_peak_blocks;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [31:0] i_cfg_data = '0;

    size_class_ring_pool_allocator_top u_top (.*);

    // Model of the pool
    logic [SLOT_W-1:0] cls_head [N_CLASSES];
    logic [SLOT_W-1:0] cls_tail [N_CLASSES];
    logic [31:0]       slot_mem [int];
    logic [31:0]       live_cnt, peak_cnt, arena_off;
    logic [31:0]       pool_base;
    logic              drop_releases;

    t_req       pending_q [$];
    t_res       expected_q [$];
    int         mismatches = 0;
    int         accepted = 0;
    logic       quiet = 1'b0;      // no idling on either side
    logic       holding = 1'b0;    // receiver held off

    // Work out the result of one item and advance the model
    function automatic t_res pool_step(t_req it);
        t_res              r;
        int                c, prv, nx;
        logic [SLOT_W-1:0] t, h;
        logic [31:0]       carried, moved;
        r.blk = '0;
        if (it.op == OP_ALLOC) begin
            if (it.size >= N_CLASSES) begin
                r.outcome = OUT_ALLOC_GH;
            end else begin
                c = int'(it.size);
                t = cls_tail[c];
                if (cls_head[c] == SLOT_W'(t + 1'b1)) begin
                    r.blk = pool_base + ARENA_GAP + arena_off;
                    arena_off = arena_off + it.size;
                    r.outcome = OUT_ARENA;
                end else begin
                    live_cnt = live_cnt - 1;
                    r.blk = slot_mem[int'(t)];
                    cls_tail[c] = SLOT_W'(t - 1'b1);
                    r.outcome = OUT_POPPED;
                end
            end
        end else if (it.size >= N_CLASSES) begin
            r.outcome = OUT_FREE_GH;
        end else if (drop_releases) begin
            r.outcome = OUT_DROPPED;
        end else begin
            // push, then shift each following class that it runs into
            c = int'(it.size);
            carried = it.handle;
            prv = c;
            nx = (c + 1) % N_CLASSES;
            cls_tail[c] = SLOT_W'(cls_tail[c] + 1'b1);
            while (nx != c) begin
                h = cls_head[nx];
                if (cls_tail[prv] != h) break;
                if (h != SLOT_W'(cls_tail[nx] + 1'b1)) begin
                    moved = slot_mem[int'(h)];
                    slot_mem[int'(h)] = carried;
                    carried = moved;
                end
                cls_head[nx] = SLOT_W'(cls_head[nx] + 1'b1);
                cls_tail[nx] = SLOT_W'(cls_tail[nx] + 1'b1);
                prv = nx;
                nx = (nx + 1) % N_CLASSES;
            end
            slot_mem[int'(cls_tail[prv])] = carried;
            live_cnt = live_cnt + 1;
            if ($signed(live_cnt) > $signed(peak_cnt)) peak_cnt = live_cnt;
            r.outcome = OUT_STORED;
        end
        r.live = live_cnt;
        r.peak = peak_cnt;
        return r;
    endfunction

    function automatic t_req mk_req(logic op, logic [31:0] size, logic [31:0] handle);
        t_req it;
        it.op = op;
        it.size = size;
        it.handle = handle;
        return it;
    endfunction

    // Random item: half aim at a few busy classes so pops find stored blocks
    function automatic t_req rand_req();
        t_req    it;
        int      r;
        int      fav [6];
        fav = '{0, 1, 2, 74, 148, 149};
        r = $urandom_range(99);
        it.op = 1'($urandom_range(1));
        it.handle = $urandom;
        if (r < 50)      it.size = fav[$urandom_range(5)];
        else if (r < 80) it.size = $urandom_range(N_CLASSES - 1);
        else if (r < 92) it.size = $urandom;
        else             it.size = N_CLASSES + $urandom_range(3);
        return it;
    endfunction

    // Clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Input driver
    always @(posedge i_clk) begin
        t_req it;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                expected_q.push_back(pool_step(mk_req(i_opcode, i_request_size,
                                                      i_block_handle)));
                accepted++;
            end
            if (!i_valid || o_ready) begin
                if (pending_q.size() > 0 && (quiet || $urandom_range(99) >= 30)) begin
                    it = pending_q.pop_front();
                    i_valid <= 1'b1;
                    i_opcode <= it.op;
                    i_request_size <= it.size;
                    i_block_handle <= it.handle;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver readiness
    always @(posedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else i_ready <= !holding && (quiet || $urandom_range(99) >= 30);
    end

    // Long hold-off so the input queue fills and stalls
    initial begin
        wait (accepted >= 300);
        @(posedge i_clk);
        holding <= 1'b1;
        repeat (600) @(posedge i_clk);
        holding <= 1'b0;
    end

    // Result checker
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: block %h outcome %0d",
                             o_result_block, o_outcome);
            end else begin
                e = expected_q.pop_front();
                if (o_result_block !== e.blk || o_outcome !== e.outcome ||
                    o_live_blocks !== e.live || o_peak_blocks !== e.peak) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: exp blk %h out %0d live %0d peak %0d,",
                                 e.blk, e.outcome, e.live, e.peak);
                        $display("          got blk %h out %0d live %0d peak %0d",
                                 o_result_block, o_outcome, o_live_blocks,
                                 o_peak_blocks);
                    end
                end
            end
        end
    end

    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_q.size() != 0 || i_valid || expected_q.size() != 0);
    endtask

    task automatic cfg_write(logic idx, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        if (idx == CFG_ARENA_BASE) pool_base = data;
        else drop_releases = data[0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Sequence of phases
    initial begin
        logic [31:0] bases [N_PHASES];
        logic        drops [N_PHASES];
        for (int i = 0; i < N_CLASSES; i++) begin
            cls_head[i] = '0;
            cls_tail[i] = SLOT_MAX;
        end
        live_cnt = '0;
        peak_cnt = '0;
        arena_off = '0;
        pool_base = '0;
        drop_releases = 1'b0;
        bases = '{32'h0, 32'hFFFF_FFFF, $urandom, 32'hFFFF_FFF8, $urandom, 32'h8000_0000};
        drops = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening
        pending_q.push_back(mk_req(OP_ALLOC, 0, 0));
        pending_q.push_back(mk_req(OP_ALLOC, N_CLASSES - 1, 0));
        pending_q.push_back(mk_req(OP_ALLOC, 1, 32'hFFFF_FFFF));
        pending_q.push_back(mk_req(OP_RELEASE, 0, 32'h0));
        pending_q.push_back(mk_req(OP_RELEASE, N_CLASSES - 1, 32'hFFFF_FFFF));
        pending_q.push_back(mk_req(OP_RELEASE, 1, 32'hA5A5_5A5A));
        pending_q.push_back(mk_req(OP_RELEASE, 0, 32'h1234_5678));
        pending_q.push_back(mk_req(OP_RELEASE, 2, 32'h5A5A_A5A5));
        pending_q.push_back(mk_req(OP_RELEASE, 1, 32'h0000_0001));
        pending_q.push_back(mk_req(OP_ALLOC, 0, 0));
        pending_q.push_back(mk_req(OP_ALLOC, 0, 0));
        pending_q.push_back(mk_req(OP_ALLOC, 0, 0));
        pending_q.push_back(mk_req(OP_ALLOC, N_CLASSES - 1, 0));
        pending_q.push_back(mk_req(OP_ALLOC, 1, 0));
        pending_q.push_back(mk_req(OP_ALLOC, 2, 0));
        pending_q.push_back(mk_req(OP_ALLOC, N_CLASSES, 0));
        pending_q.push_back(mk_req(OP_ALLOC, 32'hFFFF_FFFF, 0));
        pending_q.push_back(mk_req(OP_RELEASE, N_CLASSES, 32'hDEAD_BEEF));
        pending_q.push_back(mk_req(OP_RELEASE, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_q.push_back(mk_req(OP_ALLOC, 100, 0));
        wait_drained();

        for (int p = 0; p < N_PHASES; p++) begin
            cfg_write(CFG_ARENA_BASE, bases[p]);
            cfg_write(CFG_DISABLE, {31'b0, drops[p]});
            quiet = (p == 2);
            for (int k = 0; k < PHASE_ITEMS; k++) pending_q.push_back(rand_req());
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        if (mismatches == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end

    // Watchdog
    initial begin
        #30ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
